// File: hw/rtl/lrx_pkg.sv
package lrx_pkg;

   // Block geometry and default trig precision
   localparam int SLOTS_PER_BLOCK = 32;
   localparam int TRIG_BITS_DEF   = 16;

   // Packet codes
   localparam logic [7:0]  RET_STRONGEST = 8'h37;
   localparam logic [7:0]  RET_LAST      = 8'h38;
   localparam logic [15:0] FLAG_VALID    = 16'hEEFF;
   localparam logic [15:0] AZ_WRAP       = 16'd36000;  // one turn in 0.01 deg

   // Angle unit: 1/256 of 0.01 degree
   localparam int ANG_W     = 24;
   localparam int TURN_A    = 9216000;
   localparam int HALF_A    = 4608000;
   localparam int QUARTER_A = 2304000;
   localparam int THREEQ_A  = 6912000;

   // CORDIC
   localparam int GAIN_Q30   = 652032874;  // 0.60725293 in Q2.30
   localparam int GAIN_FRAC  = 30;
   localparam int ATAN_LEN   = 24;
   localparam int ATAN_IDX_W = 5;
   localparam int ATAN_W     = 21;
   localparam int Z_W        = 25;

   localparam logic [ATAN_W-1:0] ATAN_TAB [ATAN_LEN] = '{
      21'd1152000, 21'd680065, 21'd359328, 21'd182400,
      21'd91554,   21'd45822,  21'd22916,  21'd11459,
      21'd5730,    21'd2865,   21'd1432,   21'd716,
      21'd358,     21'd179,    21'd90,     21'd45,
      21'd22,      21'd11,     21'd6,      21'd3,
      21'd1,       21'd1,      21'd0,      21'd0
   };

   // Datapath widths
   localparam int R_W       = 22;   // range in 0.1 mm, signed
   localparam int H_W       = 23;   // horizontal range, signed
   localparam int MA_W      = 26;   // multiplier operand A, signed
   localparam int RECIP_W   = 25;   // smallest operand B, signed
   localparam int DIV_N_W   = 25;   // dividend width for the divide by 3
   localparam int DIV_SHIFT = 25;
   localparam int OFF_W     = 24;
   localparam int COORD_W   = 20;
   localparam int COORD_MAX = 524287;
   localparam int COORD_MIN = -524288;

   // floor(n / 3) = (n * RECIP3) >> DIV_SHIFT for n < 2^25
   localparam logic [23:0] RECIP3 = 24'hAAAAAB;

   // Vertical angle per laser, already wrapped into [0, turn)
   localparam logic [ANG_W-1:0] VERT_ANG [16] = '{
      24'd8832000, 24'd25600,   24'd8883200, 24'd76800,
      24'd8934400, 24'd128000,  24'd8985600, 24'd179200,
      24'd9036800, 24'd230400,  24'd9088000, 24'd281600,
      24'd9139200, 24'd332800,  24'd9190400, 24'd384000
   };

   // Range offset per laser in 0.1 mm
   localparam logic signed [7:0] OFFSET_TAB [16] = '{
      8'sd112, -8'sd7,   8'sd97,  -8'sd22,
      8'sd81,  -8'sd37,  8'sd66,  -8'sd51,
      8'sd51,  -8'sd66,  8'sd37,  -8'sd81,
      8'sd22,  -8'sd97,  8'sd7,   -8'sd112
   };

   localparam logic [3:0] RING_TAB [16] = '{
      4'd15, 4'd13, 4'd11, 4'd9, 4'd7, 4'd5, 4'd3, 4'd1,
      4'd14, 4'd12, 4'd10, 4'd8, 4'd6, 4'd4, 4'd2, 4'd0
   };

   typedef struct packed {
      logic [7:0]  return_mode;
      logic [15:0] start_flag;
      logic [15:0] block_azimuth;
      logic [15:0] next_azimuth;
      logic        last_in_packet;
      logic [4:0]  firing_slot;
      logic [15:0] distance;
      logic [7:0]  reflectivity;
   } req_item_type;

   typedef struct packed {
      logic                      status;
      logic signed [COORD_W-1:0] x_pos;
      logic signed [COORD_W-1:0] y_pos;
      logic signed [COORD_W-1:0] z_pos;
      logic [3:0]                ring;
      logic [4:0]                point_slot;
      logic [7:0]                intensity;
      logic                      new_scan;
   } rsp_item_type;

   typedef enum logic [0:0] {
      ADDR_LAST_AZ = 1'b0,
      ADDR_STEP    = 1'b1
   } state_addr_type;

   typedef struct packed {
      logic           rd_en;
      state_addr_type rd_addr;
      logic           wr_en;
      state_addr_type wr_addr;
      logic [15:0]    wr_data;
   } mem_req_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_RD_STEP,
      ST_STEP,
      ST_OFFS,
      ST_DIV3,
      ST_AZ,
      ST_CORDIC,
      ST_MH,
      ST_HR,
      ST_Z,
      ST_X,
      ST_Y,
      ST_EMIT
   } ctrl_state_type;

endpackage

// File: hw/rtl/lrx_state_mem.sv
module lrx_state_mem
   import lrx_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  mem_req_type mem_req,
   output logic [15:0] rd_data
);

   logic [15:0] store_mem [2];
   logic [1:0]  entry_valid_ff;
   logic [1:0]  entry_valid_in;
   logic [15:0] rd_word_ff;
   logic        rd_known_ff;
   logic        rd_known_in;

   // entries read as zero until first written
   always_comb begin
      entry_valid_in = entry_valid_ff;
      if (mem_req.wr_en) begin
         entry_valid_in[mem_req.wr_addr] = 1'b1;
      end
      rd_known_in = rd_known_ff;
      if (mem_req.rd_en) begin
         rd_known_in = entry_valid_ff[mem_req.rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
      end else begin
         entry_valid_ff <= entry_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         store_mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_word_ff <= store_mem[mem_req.rd_addr];
      end
      rd_known_ff <= rd_known_in;
   end

   assign rd_data = rd_known_ff ? rd_word_ff : '0;

endmodule

// File: hw/rtl/lrx_cordic.sv
module lrx_cordic
   import lrx_pkg::*;
#(
   parameter int TRIG_BITS = TRIG_BITS_DEF
)(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [ANG_W-1:0]            angle,
   output logic                        done,
   output logic signed [TRIG_BITS+1:0] sin_out,
   output logic signed [TRIG_BITS+1:0] cos_out
);

   localparam int XY_W  = TRIG_BITS + 2;
   localparam int ITERS = (TRIG_BITS < ATAN_LEN) ? TRIG_BITS : ATAN_LEN;
   localparam int X0_SH = GAIN_FRAC - (TRIG_BITS - 1);
   localparam longint X0_L = (longint'(GAIN_Q30) + (longint'(1) << (X0_SH - 1))) >> X0_SH;
   localparam logic signed [XY_W-1:0] X0 = XY_W'(X0_L);
   localparam logic [ATAN_IDX_W-1:0] LAST_ITER = ATAN_IDX_W'(ITERS - 1);

   logic signed [XY_W-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [Z_W-1:0]  z_ff, z_in;
   logic                   neg_ff, neg_in;
   logic [ATAN_IDX_W-1:0]  iter_ff, iter_in;
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;

   logic signed [Z_W-1:0]  ang_s;
   logic signed [Z_W-1:0]  atan_z;
   logic signed [XY_W-1:0] x_sh, y_sh;

   always_comb begin
      ang_s  = {1'b0, angle};
      atan_z = {{(Z_W - ATAN_W){1'b0}}, ATAN_TAB[iter_ff]};
      x_sh   = x_ff >>> iter_ff;
      y_sh   = y_ff >>> iter_ff;

      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      neg_in  = neg_ff;
      iter_in = iter_ff;
      busy_in = busy_ff;
      done_in = busy_ff && (iter_ff == LAST_ITER);

      if (start) begin
         // fold into [-90, 90] degrees; the back half negates both outputs
         x_in    = X0;
         y_in    = '0;
         iter_in = '0;
         busy_in = 1'b1;
         if (angle >= ANG_W'(THREEQ_A)) begin
            z_in   = ang_s - Z_W'(TURN_A);
            neg_in = 1'b0;
         end else if (angle > ANG_W'(QUARTER_A)) begin
            z_in   = ang_s - Z_W'(HALF_A);
            neg_in = 1'b1;
         end else begin
            z_in   = ang_s;
            neg_in = 1'b0;
         end
      end else if (busy_ff) begin
         if (!z_ff[Z_W-1]) begin
            x_in = x_ff - y_sh;
            y_in = y_ff + x_sh;
            z_in = z_ff - atan_z;
         end else begin
            x_in = x_ff + y_sh;
            y_in = y_ff - x_sh;
            z_in = z_ff + atan_z;
         end
         if (iter_ff == LAST_ITER) begin
            busy_in = 1'b0;
         end else begin
            iter_in = iter_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         iter_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         iter_ff <= iter_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      y_ff   <= y_in;
      z_ff   <= z_in;
      neg_ff <= neg_in;
   end

   assign done    = done_ff;
   assign cos_out = neg_ff ? -x_ff : x_ff;
   assign sin_out = neg_ff ? -y_ff : y_ff;

endmodule

// File: hw/rtl/lidar_return_to_xyz_point_core.sv
// Spinning-lidar return to Cartesian point converter.
//
// Input channel (req_valid / req_stall / req_item): one laser return per item,
// with the block header fields it belongs to. Output channel (rsp_valid /
// rsp_stall / rsp_item): one point per item, x/y/z in 0.04 mm. An item whose
// return mode is neither strongest nor last yields an error item (status 1,
// all else zero); other items from a block with a bad start flag yield none.
//
// Items are handled one at a time. The work is done by the CORDIC units, one
// rotation per cycle, plus the shared multiplier that runs the offset, divide
// by 3 and the four coordinate products in turn. An error item goes straight
// to the emit step; a dropped item goes back to idle.
//
// Reset clears the controller and the output valid flag; the stored block
// azimuth and azimuth step read as zero until first written. The output
// register holds while rsp_stall is high; the next item is still accepted and
// worked on, and waits in its last step until the register frees up.
module lidar_return_to_xyz_point_core
   import lrx_pkg::*;
#(
   parameter int TRIG_BITS = TRIG_BITS_DEF
)(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_item,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_item
);

   localparam int XY_W   = TRIG_BITS + 2;
   localparam int MB_W   = (XY_W > RECIP_W) ? XY_W : RECIP_W;
   localparam int PROD_W = MA_W + MB_W;
   localparam int FIN_W  = PROD_W + 3;

   localparam logic signed [PROD_W-1:0]  RND_H    = PROD_W'(1) <<< (TRIG_BITS - 2);
   localparam logic signed [FIN_W-1:0]   RND_C    = FIN_W'(1) <<< (TRIG_BITS - 1);
   localparam logic signed [FIN_W-1:0]   FIN_HI   = FIN_W'(COORD_MAX);
   localparam logic signed [FIN_W-1:0]   FIN_LO   = FIN_W'(COORD_MIN);
   localparam logic signed [COORD_W-1:0] COORD_HI = COORD_W'(COORD_MAX);
   localparam logic signed [COORD_W-1:0] COORD_LO = COORD_W'(COORD_MIN);

   // rnd(p * 5, TRIG_BITS), saturated to the coordinate range
   function automatic logic signed [COORD_W-1:0] finish_coord(
      input logic signed [PROD_W-1:0] p
   );
      logic signed [FIN_W-1:0]   v;
      logic signed [FIN_W-1:0]   q;
      logic signed [COORD_W-1:0] c;
      v = FIN_W'(p);
      v = v + (v <<< 2);
      q = (v + RND_C) >>> TRIG_BITS;
      if (q > FIN_HI) begin
         c = COORD_HI;
      end else if (q < FIN_LO) begin
         c = COORD_LO;
      end else begin
         c = q[COORD_W-1:0];
      end
      return c;
   endfunction

   // ---------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------
   ctrl_state_type            state_ff, state_in;
   req_item_type              item_ff, item_in;
   logic                      err_ff, err_in;
   logic                      scan_ff, scan_in;
   logic [15:0]               step_ff, step_in;
   logic signed [R_W-1:0]     r_ff, r_in;
   logic signed [H_W-1:0]     h_ff, h_in;
   logic signed [COORD_W-1:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_item_type              rsp_item_ff, rsp_item_in;

   // ---------------------------------------------------------------
   // Datapath helpers
   // ---------------------------------------------------------------
   mem_req_type               mem_req;
   logic [15:0]               mem_rd_data;
   logic [3:0]                laser;
   logic                      first_half;
   logic                      mode_ok;
   logic [15:0]               step_calc;
   logic [8:0]                kmul;
   logic [ANG_W:0]            az_sum;
   logic [ANG_W-1:0]          az_angle;
   logic [R_W-1:0]            dist_x20;
   logic [R_W-1:0]            off_ext;
   logic signed [PROD_W-1:0]  h_round;
   logic signed [MA_W-1:0]    mul_a;
   logic signed [MB_W-1:0]    mul_b;
   logic                      cordic_start;
   logic                      az_done, vert_done;
   logic signed [XY_W-1:0]    az_sin, az_cos, vert_sin, vert_cos;
   logic                      out_free;
   logic [3:0]                ring_val;
   rsp_item_type              point_item;

   assign laser      = item_ff.firing_slot[3:0];
   assign first_half = item_ff.firing_slot < 5'(SLOTS_PER_BLOCK / 2);
   assign mode_ok    = (item_ff.return_mode == RET_STRONGEST) ||
                       (item_ff.return_mode == RET_LAST);

   // step to the next block, unwrapped across the zero crossing, mod 2^16
   assign step_calc = item_ff.next_azimuth - item_ff.block_azimuth +
                      ((item_ff.next_azimuth < item_ff.block_azimuth) ? AZ_WRAP : 16'd0);

   // firing offset multiplier: 32k for the first firing, 16k for the second
   assign kmul = first_half ? {laser, 5'b0} : {1'b0, laser, 4'b0};

   // block azimuth * 256 plus offset stays below three turns
   always_comb begin
      az_sum = {1'b0, item_ff.block_azimuth, 8'b0} +
               (ANG_W + 1)'(prod_ff[DIV_SHIFT +: OFF_W]);
      if (az_sum >= (ANG_W + 1)'(2 * TURN_A)) begin
         az_angle = ANG_W'(az_sum - (ANG_W + 1)'(2 * TURN_A));
      end else if (az_sum >= (ANG_W + 1)'(TURN_A)) begin
         az_angle = ANG_W'(az_sum - (ANG_W + 1)'(TURN_A));
      end else begin
         az_angle = az_sum[ANG_W-1:0];
      end
   end

   // range in 0.1 mm: distance * 20 minus the per-laser offset
   assign dist_x20 = (R_W'(item_ff.distance) << 4) + (R_W'(item_ff.distance) << 2);
   assign off_ext  = {{(R_W - 8){OFFSET_TAB[laser][7]}}, OFFSET_TAB[laser]};
   assign h_round  = (prod_ff + RND_H) >>> (TRIG_BITS - 1);

   assign ring_val = RING_TAB[laser];
   always_comb begin
      point_item            = '0;
      point_item.status     = 1'b0;
      point_item.x_pos      = x_ff;
      point_item.y_pos      = y_ff;
      point_item.z_pos      = z_ff;
      point_item.ring       = ring_val;
      point_item.point_slot = {1'b0, ring_val} +
                              (first_half ? 5'd0 : 5'(SLOTS_PER_BLOCK / 2));
      point_item.intensity  = item_ff.reflectivity;
      point_item.new_scan   = scan_ff;
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // ---------------------------------------------------------------
   // Sequencer: next state, state memory access, shared multiplier
   // ---------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      err_in       = err_ff;
      scan_in      = scan_ff;
      step_in      = step_ff;
      r_in         = r_ff;
      h_in         = h_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      z_in         = z_ff;
      mem_req      = '0;
      mul_a        = '0;
      mul_b        = '0;
      cordic_start = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_item_in  = rsp_item_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               item_in  = req_item;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = ADDR_LAST_AZ;
            r_in            = $signed(dist_x20 - off_ext);
            if (!mode_ok) begin
               err_in   = 1'b1;
               state_in = ST_EMIT;
            end else if (item_ff.start_flag != FLAG_VALID) begin
               state_in = ST_IDLE;
            end else begin
               err_in   = 1'b0;
               state_in = ST_RD_STEP;
            end
         end
         ST_RD_STEP: begin
            // read data is the stored block azimuth
            scan_in         = item_ff.block_azimuth < mem_rd_data;
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = ADDR_LAST_AZ;
            mem_req.wr_data = item_ff.block_azimuth;
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = ADDR_STEP;
            state_in        = ST_STEP;
         end
         ST_STEP: begin
            // read data is the stored step; last block of a packet reuses it
            if (item_ff.last_in_packet) begin
               step_in = mem_rd_data;
            end else begin
               step_in         = step_calc;
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = ADDR_STEP;
               mem_req.wr_data = step_calc;
            end
            state_in = ST_OFFS;
         end
         ST_OFFS: begin
            mul_a    = MA_W'(step_ff);
            mul_b    = MB_W'(kmul);
            state_in = ST_DIV3;
         end
         ST_DIV3: begin
            // round to nearest: (n + 1) / 3 by reciprocal
            mul_a    = MA_W'(prod_ff[DIV_N_W-1:0]) + MA_W'(1);
            mul_b    = MB_W'(RECIP3);
            state_in = ST_AZ;
         end
         ST_AZ: begin
            cordic_start = 1'b1;
            state_in     = ST_CORDIC;
         end
         ST_CORDIC: begin
            if (az_done) begin
               state_in = ST_MH;
            end
         end
         ST_MH: begin
            mul_a    = MA_W'(r_ff);
            mul_b    = MB_W'(vert_cos);
            state_in = ST_HR;
         end
         ST_HR: begin
            h_in     = h_round[H_W-1:0];
            mul_a    = MA_W'(r_ff);
            mul_b    = MB_W'(vert_sin);
            state_in = ST_Z;
         end
         ST_Z: begin
            z_in     = finish_coord(prod_ff);
            mul_a    = MA_W'(h_ff);
            mul_b    = MB_W'(az_sin);
            state_in = ST_X;
         end
         ST_X: begin
            x_in     = finish_coord(prod_ff);
            mul_a    = MA_W'(h_ff);
            mul_b    = MB_W'(az_cos);
            state_in = ST_Y;
         end
         ST_Y: begin
            y_in     = finish_coord(prod_ff);
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (err_ff) begin
                  rsp_item_in        = '0;
                  rsp_item_in.status = 1'b1;
               end else begin
                  rsp_item_in = point_item;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      err_ff      <= err_in;
      scan_ff     <= scan_in;
      step_ff     <= step_in;
      r_ff        <= r_in;
      h_ff        <= h_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      z_ff        <= z_in;
      prod_ff     <= prod_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // ---------------------------------------------------------------
   // Units
   // ---------------------------------------------------------------
   lrx_state_mem u_state_mem (
      .clock   (clock),
      .reset   (reset),
      .mem_req (mem_req),
      .rd_data (mem_rd_data)
   );

   lrx_cordic #(
      .TRIG_BITS (TRIG_BITS)
   ) u_az_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cordic_start),
      .angle   (az_angle),
      .done    (az_done),
      .sin_out (az_sin),
      .cos_out (az_cos)
   );

   lrx_cordic #(
      .TRIG_BITS (TRIG_BITS)
   ) u_vert_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cordic_start),
      .angle   (VERT_ANG[laser]),
      .done    (vert_done),
      .sin_out (vert_sin),
      .cos_out (vert_cos)
   );

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   a_cordic_lockstep: assert property (@(posedge clock) disable iff (reset)
      az_done == vert_done)
      else $error("azimuth and vertical CORDIC units out of step");

   a_mem_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      !(mem_req.rd_en && mem_req.wr_en && (mem_req.rd_addr == mem_req.wr_addr)))
      else $error("state memory read and write hit the same entry");

   a_err_item_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_item_ff.status |->
         (rsp_item_ff.x_pos == '0) && (rsp_item_ff.y_pos == '0) &&
         (rsp_item_ff.z_pos == '0) && (rsp_item_ff.point_slot == '0) &&
         (rsp_item_ff.new_scan == 1'b0))
      else $error("error item carries point data");

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EMIT))
      else $error("result raised outside the emit step");

endmodule
